// ----- rtl/bba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and fixed codes of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	// command codes
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_COUNT = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
	localparam logic [2:0] ST_NO_BLOCK  = 3'd2;
	localparam logic [2:0] ST_NOT_OWNER = 3'd3;
	localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_CLEAR,
		S_DECODE,
		S_A_SEARCH,
		S_A_SPLIT_RD,
		S_A_SPLIT_RM,
		S_A_SPLIT_UP,
		S_A_SPLIT_LO,
		S_A_TAKE_RD,
		S_A_TAKE_RM,
		S_F_RD,
		S_F_CHECK,
		S_F_PUSH,
		S_F_BUD_RD,
		S_F_BUD_CHK,
		S_F_RM_B,
		S_F_RM_BUD,
		S_F_MERGE,
		S_C_SUM,
		S_DONE
	} bba_state_t;

	// datapath operations commanded by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_SEARCH,
		OP_SPLIT_RD,
		OP_REMOVE_B,
		OP_PUSH_UP,
		OP_PUSH_B,
		OP_TAKE_RD,
		OP_MARK_ALLOC,
		OP_F_RD,
		OP_F_PUSH,
		OP_BUD_RD,
		OP_REMOVE_BUD,
		OP_MERGE,
		OP_SUM
	} bba_op_t;

	typedef struct packed {
		bba_op_t op;
		logic    link_phase;
	} bba_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic search_hit;
		logic search_miss;
		logic at_target;
		logic free_known;
		logic free_owner_bad;
		logic free_alloc;
		logic bud_ok;
		logic lvl_zero;
		logic sum_done;
		logic link_busy;
	} bba_stat_t;

endpackage

// ----- rtl/bba_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_in_if / bba_out_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface bba_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] request_bytes;
	logic [14:0] block_address;
	logic [7:0]  task_id;
	logic        task_running;
	modport source (output valid, cmd, request_bytes, block_address, task_id,
		task_running, input ready);
	modport sink (input valid, cmd, request_bytes, block_address, task_id,
		task_running, output ready);
endinterface

interface bba_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [14:0] payload_address;
	logic [10:0] fragment_count;
	modport source (output valid, status, payload_address, fragment_count,
		input ready);
	modport sink (input valid, status, payload_address, fragment_count,
		output ready);
endinterface

// ----- rtl/bba_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Block info and link memories, free list heads and counts, request registers.
// At most two writes and two registered reads per array per cycle; link
// updates take two phases.
// ----------------------------------------------------------------------------
module bba_datapath
	import bba_pkg::*;
#(
	parameter int UNITS   = 1024,
	parameter int LEVELS  = 10,
	parameter int MINB    = 32,
	parameter int HDR     = 24,
	parameter int POOL    = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  bba_cmd_t    ctl,
	input  logic [1:0]  cmd,
	input  logic [15:0] request_bytes,
	input  logic [14:0] block_address,
	input  logic [7:0]  task_id,
	input  logic        task_running,
	output bba_stat_t   stat,
	output logic [14:0] payload_address,
	output logic [10:0] fragment_count
);
	localparam int IW = $clog2(UNITS);
	localparam int LW = $clog2(LEVELS + 1);
	localparam int MW = $clog2(MINB);
	localparam logic [IW:0] NIL = IW'(0) | (IW+1)'(UNITS);

	// block info: start, allocated, level, owner
	typedef struct packed {
		logic          start;
		logic          alloc;
		logic [LW-1:0] level;
		logic [7:0]    owner;
	} info_t;

	info_t         info_mem [UNITS];
	logic [IW:0]   next_mem [UNITS];
	logic [IW:0]   prev_mem [UNITS];
	logic [IW:0]   head_q   [LEVELS+1];
	logic [10:0]   count_q  [LEVELS+1];

	logic [IW-1:0] clr_q;
	logic          clr_done_q;
	logic [IW-1:0] b_q, bud_q, up_q;
	logic [LW-1:0] lvl_q, tgt_q, cnt_l_q;
	info_t         inf_q;
	logic [IW:0]   np_q, pp_q;
	logic [10:0]   sum_q;
	logic [16:0]   bytes_q;
	logic [2:0]    st_q;
	logic [15:0]   rq_q;
	logic [7:0]    tid_q;
	logic          run_q;
	logic          addr_ok_q;
	logic          owner_bad, known;
	logic [14:0]   addr_off;
	logic [7:0]    own_val;

	assign addr_off = block_address - 15'(HDR);
	assign own_val  = run_q ? tid_q : 8'd0;

	// target level of an allocate, from request plus header
	function automatic logic [LW-1:0] level_for(input logic [16:0] by);
		logic [LW-1:0] r;
		r = '0;
		for (int k = 0; k <= LEVELS; k++)
			if (by <= 17'(MINB << k) && r == '0) r = LW'(LEVELS - k);
		return r;
	endfunction

	// status decode
	assign known = addr_ok_q && inf_q.start;
	assign owner_bad = run_q && inf_q.owner != tid_q;
	always_comb begin
		stat = '0;
		stat.clear_done     = clr_done_q;
		stat.search_hit     = head_q[lvl_q] != NIL;
		stat.search_miss    = head_q[lvl_q] == NIL && lvl_q == '0;
		stat.at_target      = lvl_q == tgt_q;
		stat.free_known     = known;
		stat.free_owner_bad = owner_bad;
		stat.free_alloc     = inf_q.alloc;
		stat.bud_ok         = inf_q.start && !inf_q.alloc && inf_q.level == lvl_q;
		stat.lvl_zero       = lvl_q == '0;
		stat.sum_done       = cnt_l_q == LW'(LEVELS);
		stat.link_busy      = 1'b0;
	end

	// block size at a level in bytes compared with the request
	function automatic logic smaller(input logic [LW-1:0] l, input logic [15:0] rq);
		return (32'(MINB) << (LEVELS - int'(l))) < 32'(rq);
	endfunction

	// registers with reset: clear counter, free list heads and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_done_q <= 1'b0;
			for (int l = 0; l <= LEVELS; l++) begin
				head_q[l]  <= (l == 0) ? '0 : NIL;
				count_q[l] <= (l == 0) ? 11'd1 : 11'd0;
			end
		end else begin
			case (ctl.op)
				OP_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(UNITS - 1)) clr_done_q <= 1'b1;
				end
				OP_SEARCH: begin
				end
				OP_REMOVE_B, OP_REMOVE_BUD: begin
					if (!ctl.link_phase) begin
					end else begin
						if (pp_q == NIL) head_q[lvl_q] <= np_q;
						count_q[lvl_q] <= count_q[lvl_q] - 11'd1;
					end
				end
				OP_PUSH_UP: begin
					head_q[lvl_q + 1'b1]  <= {1'b0, up_q};
					count_q[lvl_q + 1'b1] <= count_q[lvl_q + 1'b1] + 11'd1;
				end
				OP_PUSH_B: begin
					head_q[lvl_q + 1'b1]  <= {1'b0, b_q};
					count_q[lvl_q + 1'b1] <= count_q[lvl_q + 1'b1] + 11'd1;
				end
				OP_F_PUSH: begin
					head_q[lvl_q]  <= {1'b0, b_q};
					count_q[lvl_q] <= count_q[lvl_q] + 11'd1;
				end
				OP_MERGE: begin
					head_q[lvl_q - 1'b1]  <= {1'b0, b_q & bud_q};
					count_q[lvl_q - 1'b1] <= count_q[lvl_q - 1'b1] + 11'd1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers and memory ports
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_CLEAR: begin
				info_mem[clr_q] <= (clr_q == '0) ? info_t'{1'b1, 1'b0, LW'(0), 8'd0}
					: info_t'{1'b0, 1'b0, LW'(0), 8'd0};
				if (clr_q == '0) begin
					next_mem[clr_q] <= NIL;
					prev_mem[clr_q] <= NIL;
				end
			end
			OP_LOAD: begin
				bytes_q <= {1'b0, request_bytes} + 17'(HDR);
				tgt_q   <= level_for({1'b0, request_bytes} + 17'(HDR));
				lvl_q   <= level_for({1'b0, request_bytes} + 17'(HDR));
				b_q     <= addr_off[IW+MW-1:MW];
				inf_q   <= info_mem[addr_off[IW+MW-1:MW]];
				rq_q    <= request_bytes;
				tid_q   <= task_id;
				run_q   <= task_running;
				addr_ok_q <= (block_address >= 15'(HDR)) && (addr_off[MW-1:0] == '0);
				sum_q   <= '0;
				cnt_l_q <= '0;
				st_q    <= ST_OK;
				payload_address <= '0;
				fragment_count  <= '0;
			end
			OP_SEARCH: lvl_q <= lvl_q - 1'b1;
			OP_SPLIT_RD, OP_TAKE_RD: begin
				b_q  <= head_q[lvl_q][IW-1:0];
				np_q <= next_mem[head_q[lvl_q][IW-1:0]];
				pp_q <= NIL;
				up_q <= head_q[lvl_q][IW-1:0] | IW'(UNITS >> (int'(lvl_q) + 1));
			end
			OP_REMOVE_B, OP_REMOVE_BUD: begin
				if (!ctl.link_phase) begin
					if (pp_q != NIL) next_mem[pp_q[IW-1:0]] <= np_q;
				end else begin
					if (np_q != NIL) prev_mem[np_q[IW-1:0]] <= pp_q;
					// read the buddy links for the following removal; a buddy
					// right after the removed block takes its predecessor
					np_q <= next_mem[bud_q];
					pp_q <= (np_q == {1'b0, bud_q}) ? pp_q : prev_mem[bud_q];
				end
			end
			OP_PUSH_UP: begin
				info_mem[b_q] <= info_t'{1'b1, 1'b0, lvl_q + 1'b1, 8'd0};
				info_mem[up_q] <= info_t'{1'b1, 1'b0, lvl_q + 1'b1, 8'd0};
				next_mem[up_q] <= head_q[lvl_q + 1'b1];
				prev_mem[up_q] <= NIL;
				if (head_q[lvl_q + 1'b1] != NIL)
					prev_mem[head_q[lvl_q + 1'b1][IW-1:0]] <= {1'b0, up_q};
			end
			OP_PUSH_B: begin
				next_mem[b_q] <= {1'b0, up_q};
				prev_mem[b_q] <= NIL;
				prev_mem[up_q] <= {1'b0, b_q};
				lvl_q <= lvl_q + 1'b1;
			end
			OP_MARK_ALLOC: begin
				info_mem[b_q] <= info_t'{1'b1, 1'b1, tgt_q, own_val};
				payload_address <= 15'({b_q, MW'(0)} + (IW+MW)'(HDR));
			end
			OP_F_RD: begin
				lvl_q <= inf_q.level;
				st_q  <= !known ? ST_NOT_ALLOC : owner_bad ? ST_NOT_OWNER
					: !inf_q.alloc ? ST_NOT_ALLOC : ST_OK;
			end
			OP_F_PUSH: begin
				info_mem[b_q] <= info_t'{1'b1, 1'b0, lvl_q, 8'd0};
				next_mem[b_q] <= head_q[lvl_q];
				prev_mem[b_q] <= NIL;
				if (head_q[lvl_q] != NIL) prev_mem[head_q[lvl_q][IW-1:0]] <= {1'b0, b_q};
			end
			OP_BUD_RD: begin
				bud_q <= b_q ^ IW'(UNITS >> int'(lvl_q));
				inf_q <= info_mem[b_q ^ IW'(UNITS >> int'(lvl_q))];
				np_q  <= next_mem[b_q];
				pp_q  <= prev_mem[b_q];
			end
			OP_MERGE: begin
				info_mem[b_q | bud_q] <= info_t'{1'b0, 1'b0, lvl_q, 8'd0};
				info_mem[b_q & bud_q] <= info_t'{1'b1, 1'b0, lvl_q - 1'b1, 8'd0};
				next_mem[b_q & bud_q] <= head_q[lvl_q - 1'b1];
				prev_mem[b_q & bud_q] <= NIL;
				if (head_q[lvl_q - 1'b1] != NIL)
					prev_mem[head_q[lvl_q - 1'b1][IW-1:0]] <= {1'b0, b_q & bud_q};
				b_q   <= b_q & bud_q;
				lvl_q <= lvl_q - 1'b1;
			end
			OP_SUM: begin
				if (rq_q > 16'(MINB) && smaller(cnt_l_q, rq_q))
					sum_q <= sum_q + count_q[cnt_l_q];
				cnt_l_q <= cnt_l_q + 1'b1;
				fragment_count <= (rq_q > 16'(MINB) &&
					smaller(cnt_l_q, rq_q)) ? sum_q + count_q[cnt_l_q] : sum_q;
			end
			default: begin
			end
		endcase
	end

	logic unused_bits;
	assign unused_bits = ^{cmd, bytes_q, st_q, POOL[0]};

endmodule

// ----- rtl/bba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for allocate, free and count; drives datapath operations and the
// handshakes.
// ----------------------------------------------------------------------------
module bba_ctrl
	import bba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] request_bytes,
	input  logic        bad_size,
	input  bba_stat_t   stat,
	output bba_cmd_t    ctl,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status
);
	bba_state_t state_q, state_d;
	logic       phase_q, phase_d;
	logic [2:0] st_q, st_d;
	logic [1:0] cmd_q;
	logic       bad_q;
	logic       load;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			phase_q <= 1'b0;
			st_q    <= ST_OK;
			cmd_q   <= CMD_ALLOC;
			bad_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			st_q    <= st_d;
			if (load) begin
				cmd_q <= cmd;
				bad_q <= bad_size;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		phase_d = 1'b0;
		st_d    = st_q;
		ctl     = '{op: OP_NONE, link_phase: phase_q};
		in_ready  = 1'b0;
		out_valid = 1'b0;
		load      = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ctl.op = OP_CLEAR;
				if (stat.clear_done) begin
					ctl.op  = OP_NONE;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					load    = 1'b1;
					ctl.op  = OP_LOAD;
					st_d    = ST_OK;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (cmd_q)
					CMD_ALLOC: begin
						if (bad_q) begin
							st_d    = ST_BAD_SIZE;
							state_d = S_DONE;
						end else state_d = S_A_SEARCH;
					end
					CMD_FREE: begin
						ctl.op  = OP_F_RD;
						state_d = S_F_CHECK;
					end
					CMD_COUNT: state_d = S_C_SUM;
					default: state_d = S_DONE;
				endcase
			end
			S_A_SEARCH: begin
				if (stat.search_hit) begin
					state_d = stat.at_target ? S_A_TAKE_RD : S_A_SPLIT_RD;
				end else if (stat.search_miss) begin
					st_d    = ST_NO_BLOCK;
					state_d = S_DONE;
				end else ctl.op = OP_SEARCH;
			end
			S_A_SPLIT_RD: begin
				ctl.op  = OP_SPLIT_RD;
				state_d = S_A_SPLIT_RM;
			end
			S_A_SPLIT_RM: begin
				ctl.op  = OP_REMOVE_B;
				phase_d = !phase_q;
				if (phase_q) state_d = S_A_SPLIT_UP;
			end
			S_A_SPLIT_UP: begin
				ctl.op  = OP_PUSH_UP;
				state_d = S_A_SPLIT_LO;
			end
			S_A_SPLIT_LO: begin
				ctl.op  = OP_PUSH_B;
				state_d = S_A_SEARCH;
			end
			S_A_TAKE_RD: begin
				ctl.op  = OP_TAKE_RD;
				state_d = S_A_TAKE_RM;
			end
			S_A_TAKE_RM: begin
				ctl.op  = OP_REMOVE_B;
				phase_d = !phase_q;
				if (phase_q) state_d = S_F_RD;
			end
			S_F_RD: begin
				ctl.op  = OP_MARK_ALLOC;
				state_d = S_DONE;
			end
			S_F_CHECK: begin
				if (!stat.free_known) st_d = ST_NOT_ALLOC;
				else if (stat.free_owner_bad) st_d = ST_NOT_OWNER;
				else if (!stat.free_alloc) st_d = ST_NOT_ALLOC;
				state_d = (!stat.free_known || stat.free_owner_bad || !stat.free_alloc)
					? S_DONE : S_F_PUSH;
			end
			S_F_PUSH: begin
				ctl.op  = OP_F_PUSH;
				state_d = S_F_BUD_RD;
			end
			S_F_BUD_RD: begin
				if (stat.lvl_zero) state_d = S_DONE;
				else begin
					ctl.op  = OP_BUD_RD;
					state_d = S_F_BUD_CHK;
				end
			end
			S_F_BUD_CHK: state_d = stat.bud_ok ? S_F_RM_B : S_DONE;
			S_F_RM_B: begin
				ctl.op  = OP_REMOVE_B;
				phase_d = !phase_q;
				if (phase_q) state_d = S_F_RM_BUD;
			end
			S_F_RM_BUD: begin
				ctl.op  = OP_REMOVE_BUD;
				phase_d = !phase_q;
				if (phase_q) state_d = S_F_MERGE;
			end
			S_F_MERGE: begin
				ctl.op  = OP_MERGE;
				state_d = S_F_BUD_RD;
			end
			S_C_SUM: begin
				ctl.op = OP_SUM;
				if (stat.sum_done) state_d = S_DONE;
			end
			S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign status = st_q;

	logic unused_in;
	assign unused_in = ^{request_bytes, stat.link_busy, stat.search_miss};

endmodule

// ----- rtl/buddy_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a pool of power-of-two blocks with per-level free lists.
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass over all UNITS block
// entries (1024 by default) initializes block info; no request is taken until
// it ends. An allocate searches the free lists and, per split, takes a search
// step, a head read, a two-phase unlink and two pushes, then takes and marks
// the block; a free checks the block and, unless rejected, pushes it and merges
// with each free buddy until a buddy is not free or it reaches the whole pool;
// a count sums the levels one at a time; bad size or unknown command respond
// directly. Worst case is ten splits, set by the list memories walked one level
// at a time. The next request is taken only after the response handshake.
module buddy_block_allocator
	import bba_pkg::*;
#(
	parameter int POOL_BYTES      = 32768,
	parameter int MIN_BLOCK_BYTES = 32,
	parameter int LEVELS          = 10,
	parameter int HEADER_BYTES    = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	bba_in_if.sink    req,
	bba_out_if.source rsp
);
	localparam int UNITS = POOL_BYTES / MIN_BLOCK_BYTES;

	bba_cmd_t  ctl;
	bba_stat_t stat;
	logic      bad_size;

	// size check for allocate
	assign bad_size = req.request_bytes == 16'd0 ||
		({1'b0, req.request_bytes} + 17'(HEADER_BYTES)) > 17'(POOL_BYTES);

	bba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.cmd(req.cmd), .request_bytes(req.request_bytes), .bad_size(bad_size),
		.stat(stat), .ctl(ctl),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .status(rsp.status)
	);

	bba_datapath #(
		.UNITS(UNITS), .LEVELS(LEVELS), .MINB(MIN_BLOCK_BYTES),
		.HDR(HEADER_BYTES), .POOL(POOL_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.cmd(req.cmd), .request_bytes(req.request_bytes),
		.block_address(req.block_address), .task_id(req.task_id),
		.task_running(req.task_running), .stat(stat),
		.payload_address(rsp.payload_address),
		.fragment_count(rsp.fragment_count)
	);

endmodule

// ----- rtl/bba_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the allocator's request and response behavior.
// ----------------------------------------------------------------------------
module bba_checker
	import bba_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [14:0] payload_address
);
	// no new request while a response waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready during response");

	// status within codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_NOT_ALLOC) else $error("bad status");

	// a failed request returns no address
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> payload_address == 15'd0)
		else $error("address on error");

	// response holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("response dropped");
endmodule

bind buddy_block_allocator bba_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready),
	.status(rsp.status), .payload_address(rsp.payload_address)
);
